>>> sv/fesq_pkg.sv
// fesq_pkg: shared types, constants and command codes of the flash erase/program sequencer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package fesq_pkg;

    // Sizing
    localparam int ADDR_BITS    = 20;
    localparam int SECTOR_WORDS = 32768;
    localparam int DATA_BITS    = 16;
    localparam int LIMIT_BITS   = 13;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_BITS-1:0] REG_ERASE_LIMIT   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PROGRAM_LIMIT = 2'd1;
    localparam logic [LIMIT_BITS-1:0]   ERASE_LIMIT_RST   = 13'd5000;
    localparam logic [LIMIT_BITS-1:0]   PROGRAM_LIMIT_RST = 13'd10;

    // Input opcodes
    localparam logic [1:0] OP_ERASE   = 2'd0;
    localparam logic [1:0] OP_PROGRAM = 2'd1;
    localparam logic [1:0] OP_DATA    = 2'd2;
    localparam logic [1:0] OP_STATUS  = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DONE  = 2'd2;
    localparam logic [1:0] KIND_NEXT  = 2'd3;

    // Outcomes
    localparam logic [2:0] OUT_OK      = 3'd0;
    localparam logic [2:0] OUT_VOLTAGE = 3'd1;
    localparam logic [2:0] OUT_PROTECT = 3'd2;
    localparam logic [2:0] OUT_PROGERR = 3'd3;
    localparam logic [2:0] OUT_TIMEOUT = 3'd4;
    localparam logic [2:0] OUT_BAD     = 3'd5;

    // Flash commands
    localparam logic [DATA_BITS-1:0] CMD_READ    = 16'h00FF;
    localparam logic [DATA_BITS-1:0] CMD_ERASE   = 16'h0020;
    localparam logic [DATA_BITS-1:0] CMD_CONFIRM = 16'h00D0;
    localparam logic [DATA_BITS-1:0] CMD_CLEAR   = 16'h0050;
    localparam logic [DATA_BITS-1:0] CMD_PROGRAM = 16'h0040;
    localparam logic [DATA_BITS-1:0] CMD_STATUS  = 16'h0070;

    // Status register bits
    localparam int ST_VOLTAGE_BIT = 3;
    localparam int ST_PROTECT_BIT = 1;
    localparam int ST_PROGERR_BIT = 4;
    localparam int ST_READY_BIT   = 7;

    // Bus sequences the back end knows how to expand
    typedef enum logic [2:0] {
        SEQ_ERASE,   // clear, read array, erase, confirm, status, read
        SEQ_PSTART,  // clear, read array, next
        SEQ_DATA,    // program, data, status, read
        SEQ_POLL,    // status, read
        SEQ_FINISH,  // clear, read array, done
        SEQ_NEXT,    // next
        SEQ_BAD      // done with outcome "unexpected"
    } seq_t;

    // One queued job handed from front to back
    typedef struct packed {
        seq_t                  seq;
        logic [ADDR_BITS-1:0]  addr;
        logic [DATA_BITS-1:0]  value;
        logic [2:0]            outcome;
    } desc_t;

endpackage

`default_nettype wire

>>> sv/fesq_front.sv
// fesq_front: accepts input words, tracks job phase/counters, emits one descriptor per word.
// Depends on fesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fesq_front (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   push,
    input  wire                                   q_full,
    input  wire [1:0]                             op,
    input  wire [fesq_pkg::ADDR_BITS-1:0]         address,
    input  wire [fesq_pkg::DATA_BITS-1:0]         value,
    input  wire                                   cfg_valid,
    input  wire [fesq_pkg::CFG_IDX_BITS-1:0]      cfg_index,
    input  wire [fesq_pkg::LIMIT_BITS-1:0]        cfg_data,
    output logic                                  q_push,
    output fesq_pkg::desc_t                       q_desc
);
    import fesq_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ERASE_POLL,
        PH_PROG_DATA,
        PH_PROG_POLL
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [ADDR_BITS-1:0]   sector_base_reg, sector_base_next;
    logic [ADDR_BITS-1:0]   word_address_reg, word_address_next;
    logic [15:0]            words_done_reg, words_done_next;
    logic [LIMIT_BITS-1:0]  poll_count_reg, poll_count_next;
    logic [LIMIT_BITS-1:0]  erase_limit_reg, program_limit_reg;

    logic                   accept;
    logic                   erasing;
    logic [ADDR_BITS-1:0]   where;
    logic [LIMIT_BITS-1:0]  poll_inc;
    logic [LIMIT_BITS-1:0]  limit;
    logic [2:0]             code;
    logic [16:0]            done_inc;
    logic [ADDR_BITS-1:0]   wa_inc;

    assign accept   = push && !q_full;
    assign q_push   = accept;
    assign erasing  = (phase_reg == PH_ERASE_POLL);
    assign where    = erasing ? sector_base_reg : word_address_reg;
    assign poll_inc = poll_count_reg + 1'b1;
    assign limit    = erasing ? erase_limit_reg : program_limit_reg;
    assign done_inc = {1'b0, words_done_reg} + 17'd1;
    assign wa_inc   = word_address_reg + 1'b1;

    // status error priority: voltage, protect, programming
    always_comb
    begin
        if (value[ST_VOLTAGE_BIT])
            code = OUT_VOLTAGE;
        else if (value[ST_PROTECT_BIT])
            code = OUT_PROTECT;
        else if (value[ST_PROGERR_BIT])
            code = OUT_PROGERR;
        else
            code = OUT_OK;
    end

    always_comb
    begin
        phase_next        = phase_reg;
        sector_base_next  = sector_base_reg;
        word_address_next = word_address_reg;
        words_done_next   = words_done_reg;
        poll_count_next   = poll_count_reg;
        q_desc.seq        = SEQ_FINISH;
        q_desc.addr       = sector_base_reg;
        q_desc.value      = '0;
        q_desc.outcome    = OUT_BAD;

        if (phase_reg == PH_IDLE && op == OP_ERASE)
        begin
            q_desc.seq       = SEQ_ERASE;
            q_desc.addr      = address;
            sector_base_next = address;
            poll_count_next  = '0;
            phase_next       = PH_ERASE_POLL;
        end
        else if (phase_reg == PH_IDLE && op == OP_PROGRAM)
        begin
            q_desc.seq        = SEQ_PSTART;
            q_desc.addr       = address;
            sector_base_next  = address;
            word_address_next = address;
            words_done_next   = '0;
            poll_count_next   = '0;
            phase_next        = PH_PROG_DATA;
        end
        else if (phase_reg == PH_PROG_DATA && op == OP_DATA)
        begin
            q_desc.seq      = SEQ_DATA;
            q_desc.addr     = word_address_reg;
            q_desc.value    = value;
            poll_count_next = '0;
            phase_next      = PH_PROG_POLL;
        end
        else if ((phase_reg == PH_ERASE_POLL || phase_reg == PH_PROG_POLL)
                 && op == OP_STATUS)
        begin
            if (!value[ST_READY_BIT])
            begin
                if (poll_inc == limit)
                begin
                    q_desc.outcome  = OUT_TIMEOUT;
                    phase_next      = PH_IDLE;
                    poll_count_next = '0;
                end
                else
                begin
                    q_desc.seq      = SEQ_POLL;
                    q_desc.addr     = where;
                    poll_count_next = poll_inc;
                end
            end
            else if (erasing || code != OUT_OK)
            begin
                q_desc.outcome  = code;
                phase_next      = PH_IDLE;
                poll_count_next = '0;
            end
            else
            begin
                words_done_next   = done_inc[15:0];
                word_address_next = wa_inc;
                if (done_inc >= 17'(SECTOR_WORDS))
                begin
                    q_desc.outcome  = OUT_OK;
                    phase_next      = PH_IDLE;
                    poll_count_next = '0;
                end
                else
                begin
                    q_desc.seq      = SEQ_NEXT;
                    q_desc.addr     = wa_inc;
                    poll_count_next = '0;
                    phase_next      = PH_PROG_DATA;
                end
            end
        end
        else if (phase_reg == PH_IDLE)
        begin
            q_desc.seq = SEQ_BAD;
        end
        else
        begin
            // busy and the word does not fit: abort the job
            phase_next      = PH_IDLE;
            poll_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            sector_base_reg   <= '0;
            word_address_reg  <= '0;
            words_done_reg    <= '0;
            poll_count_reg    <= '0;
            erase_limit_reg   <= ERASE_LIMIT_RST;
            program_limit_reg <= PROGRAM_LIMIT_RST;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                sector_base_reg  <= sector_base_next;
                word_address_reg <= word_address_next;
                words_done_reg   <= words_done_next;
                poll_count_reg   <= poll_count_next;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ERASE_LIMIT:   erase_limit_reg   <= cfg_data;
                    REG_PROGRAM_LIMIT: program_limit_reg <= cfg_data;
                    default:           ;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/fesq_queue.sv
// fesq_queue: two-entry descriptor queue between front and back end.
// Depends on fesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fesq_queue (
    input  wire                   clk,
    input  wire                   rst_n,
    input  wire                   push,
    input  wire fesq_pkg::desc_t  push_desc,
    output logic                  full,
    input  wire                   pop,
    output logic                  head_valid,
    output fesq_pkg::desc_t       head_desc
);
    import fesq_pkg::*;

    desc_t       entry_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head_desc  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                count_reg <= count_reg + 2'd1;
            else if (pop && !push)
                count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

>>> sv/fesq_back.sv
// fesq_back: expands queued jobs into output register bus words, one per cycle if not stalled.
// Depends on fesq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fesq_back (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            head_valid,
    input  wire fesq_pkg::desc_t           head_desc,
    output logic                           q_pop,
    input  wire                            pop,
    output logic                           empty,
    output logic [1:0]                     kind,
    output logic [fesq_pkg::ADDR_BITS-1:0] bus_address,
    output logic [fesq_pkg::DATA_BITS-1:0] bus_value,
    output logic                           vpp_enable,
    output logic [2:0]                     outcome,
    output logic                           last
);
    import fesq_pkg::*;

    logic [2:0]            step_reg;
    logic                  out_valid_reg;
    logic [1:0]            kind_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [DATA_BITS-1:0]  value_reg;
    logic [2:0]            outcome_reg;
    logic                  last_reg;

    logic [1:0]            w_kind;
    logic [DATA_BITS-1:0]  w_value;
    logic [2:0]            w_outcome;
    logic                  w_last;
    logic                  pop_ok;
    logic                  load;

    assign pop_ok = pop && out_valid_reg;
    assign load   = head_valid && (!out_valid_reg || pop_ok);
    assign q_pop  = load && w_last;

    // word at position step_reg of the head sequence
    always_comb
    begin
        w_kind    = KIND_WRITE;
        w_value   = '0;
        w_outcome = OUT_OK;
        w_last    = 1'b0;
        case (head_desc.seq)
            SEQ_ERASE:
            begin
                case (step_reg)
                    3'd0:    w_value = CMD_CLEAR;
                    3'd1:    w_value = CMD_READ;
                    3'd2:    w_value = CMD_ERASE;
                    3'd3:    w_value = CMD_CONFIRM;
                    3'd4:    w_value = CMD_STATUS;
                    default:
                    begin
                        w_kind = KIND_READ;
                        w_last = 1'b1;
                    end
                endcase
            end
            SEQ_PSTART:
            begin
                case (step_reg)
                    3'd0:    w_value = CMD_CLEAR;
                    3'd1:    w_value = CMD_READ;
                    default:
                    begin
                        w_kind = KIND_NEXT;
                        w_last = 1'b1;
                    end
                endcase
            end
            SEQ_DATA:
            begin
                case (step_reg)
                    3'd0:    w_value = CMD_PROGRAM;
                    3'd1:    w_value = head_desc.value;
                    3'd2:    w_value = CMD_STATUS;
                    default:
                    begin
                        w_kind = KIND_READ;
                        w_last = 1'b1;
                    end
                endcase
            end
            SEQ_POLL:
            begin
                case (step_reg)
                    3'd0:    w_value = CMD_STATUS;
                    default:
                    begin
                        w_kind = KIND_READ;
                        w_last = 1'b1;
                    end
                endcase
            end
            SEQ_FINISH:
            begin
                case (step_reg)
                    3'd0:    w_value = CMD_CLEAR;
                    3'd1:    w_value = CMD_READ;
                    default:
                    begin
                        w_kind    = KIND_DONE;
                        w_outcome = head_desc.outcome;
                        w_last    = 1'b1;
                    end
                endcase
            end
            SEQ_NEXT:
            begin
                w_kind = KIND_NEXT;
                w_last = 1'b1;
            end
            default:
            begin
                w_kind    = KIND_DONE;
                w_outcome = OUT_BAD;
                w_last    = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            step_reg      <= w_last ? 3'd0 : step_reg + 3'd1;
            out_valid_reg <= 1'b1;
        end
        else if (pop_ok)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg    <= w_kind;
            addr_reg    <= head_desc.addr;
            value_reg   <= w_value;
            outcome_reg <= w_outcome;
            last_reg    <= w_last;
        end
    end

    assign empty       = !out_valid_reg;
    assign kind        = kind_reg;
    assign bus_address = addr_reg;
    assign bus_value   = value_reg;
    // VPP is up for the whole of a job and only a done word sees it dropped
    assign vpp_enable  = (kind_reg != KIND_DONE);
    assign outcome     = outcome_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

>>> sv/flash_erase_program_sequencer_core.sv
// flash_erase_program_sequencer_core: top level of the NOR flash erase/program sequencer.
// Instantiates fesq_front, fesq_queue and fesq_back; depends on fesq_pkg.
//
// Usage:
//  - Input queue side: present op/address/value and raise push; the word is taken on a
//    clock edge with push high and full low. op selects start erase, start program,
//    data halfword or a status value read back from the flash.
//  - Result queue side: while empty is low, kind/bus_address/bus_value/vpp_enable/
//    outcome/last hold the oldest result word; pop with empty low takes it. last marks
//    the final result word caused by an input word.
//  - Config channel: cfg_valid/cfg_ready with cfg_index (0 erase poll limit, 1 program
//    poll limit) and cfg_data; cfg_ready is always high. Write only while idle.
//  - Flow: the first result word of an input word passes through the job queue and then the
//    output register. Each input word expands into 1 to 6 result words, delivered one per
//    cycle by the back end while pop keeps up, so the sustained rate of input words is set
//    by the word count of their bus sequences. The front takes a new word every cycle while
//    the two-entry job queue has room.
//  - When pop is held low the output register holds, the job queue fills, and full rises.
//  - Reset (async, rst_n low) returns to idle, counters cleared, limits back to 5000 and
//    10, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module flash_erase_program_sequencer_core (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  push,
    output logic                                 full,
    input  wire [1:0]                            op,
    input  wire [fesq_pkg::ADDR_BITS-1:0]        address,
    input  wire [fesq_pkg::DATA_BITS-1:0]        value,
    output logic                                 empty,
    input  wire                                  pop,
    output logic [1:0]                           kind,
    output logic [fesq_pkg::ADDR_BITS-1:0]       bus_address,
    output logic [fesq_pkg::DATA_BITS-1:0]       bus_value,
    output logic                                 vpp_enable,
    output logic [2:0]                           outcome,
    output logic                                 last,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire [fesq_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire [fesq_pkg::LIMIT_BITS-1:0]       cfg_data
);
    import fesq_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_pop;
    logic   head_valid;
    desc_t  push_desc;
    desc_t  head_desc;

    // config writes are taken whenever cfg_valid is high, never back-pressured
    assign cfg_ready = 1'b1;
    assign full      = q_full;

    fesq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .q_full    (q_full),
        .op        (op),
        .address   (address),
        .value     (value),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (q_push),
        .q_desc    (push_desc)
    );

    // job queue decouples classification from bus word expansion
    fesq_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_desc  (push_desc),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_desc  (head_desc)
    );

    fesq_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (head_valid),
        .head_desc   (head_desc),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .kind        (kind),
        .bus_address (bus_address),
        .bus_value   (bus_value),
        .vpp_enable  (vpp_enable),
        .outcome     (outcome),
        .last        (last)
    );

endmodule

`default_nettype wire
